### rtl/vae_pkg.sv
// package: constants, types and helpers of the vector arrow endpoint
package vae_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT = 24;
  localparam int VW = 48;                          // cordic datapath width
  localparam logic signed [20:0] COMP_GAIN = 21'sd636751;
  localparam logic signed [23:0] OUT_MAX = 24'sd8388607;
  localparam logic signed [23:0] OUT_MIN = -24'sd8388608;
  localparam logic signed [24:0] DEG90 = 25'sd23040;
  localparam logic signed [24:0] DEG450 = 25'sd115200;
  localparam logic signed [24:0] HALF_PI = 25'sd102944;
  localparam logic signed [24:0] FIVE_HALF_PI = 25'sd514719;
  localparam logic [29:0] RAD_TO_PHASE = 30'd683565276;

  // exact divide by 45 of a value below 2^29: (x * ceil(2^35/45)) >> 35
  localparam logic [29:0] DIV45_MAGIC = 30'd763549742;
  // degrees Q16.8: phase = a*floor(2^21/45) + floor(17a/45), mod 2^32
  localparam logic signed [40:0] DEG_K = 41'sd46603;
  localparam logic signed [29:0] DEG_R = 30'sd17;
  localparam logic signed [29:0] DEG_OFS = 30'sd377487360;  // 45 * 2^23
  localparam logic [31:0] DEG_OFS_Q = 32'd8388608;
  // rotation Q10.7: phase = m*floor(2^22/45) + floor(34m/45), mod 2^32
  localparam logic signed [34:0] ROT_K = 35'sd93206;
  localparam logic signed [24:0] ROT_R = 25'sd34;
  localparam logic signed [24:0] ROT_OFS = 25'sd5898240;    // 45 * 2^17
  localparam logic [31:0] ROT_OFS_Q = 32'd131072;

  // register indexes
  localparam logic [2:0] REG_FIELD_TYPE = 3'd0;
  localparam logic [2:0] REG_ORIENT = 3'd1;
  localparam logic [2:0] REG_UNITS = 3'd2;
  localparam logic [2:0] REG_GAIN = 3'd3;
  localparam logic [2:0] REG_ROTATION = 3'd4;

  // field types
  localparam logic [1:0] FT_CARTESIAN = 2'd0;
  localparam logic [1:0] FT_POLAR = 2'd1;

  typedef logic signed [VW-1:0] vec_t;

  // arctangent table in binary phase units
  function automatic logic [29:0] atan_phase(input int i);
    logic [29:0] t [ATAN_COUNT];
    t = '{30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
          30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
          30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
          30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
          30'd81};
    return t[i];
  endfunction

  // one cordic micro-rotation step
  typedef struct packed {
    vec_t x;
    vec_t y;
    logic signed [31:0] z;
  } rot_t;

endpackage

### rtl/vae_cordic.sv
// pipelined cordic rotator: quadrant fold, micro-rotations, gain compensation
module vae_cordic
  import vae_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  vec_t        x_in,
  input  vec_t        y_in,
  input  logic [31:0] phase,
  output vec_t        x_out,
  output vec_t        y_out
);

  rot_t st [CORDIC_STAGES+1];
  rot_t fold;
  vec_t xc;
  vec_t yc;
  logic signed [VW+20:0] px;
  logic signed [VW+20:0] py;
  logic signed [VW+20:0] pxr;
  logic signed [VW+20:0] pyr;

  // exact quadrant rotation
  always_comb begin
    fold.z = $signed({2'b00, phase[29:0]});
    case (phase[31:30])
      2'd1: begin fold.x = -y_in; fold.y = x_in; end
      2'd2: begin fold.x = -x_in; fold.y = -y_in; end
      2'd3: begin fold.x = y_in; fold.y = -x_in; end
      default: begin fold.x = x_in; fold.y = y_in; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= fold;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!st[i].z[31]) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - $signed({2'b00, atan_phase(i)});
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + $signed({2'b00, atan_phase(i)});
        end
      end
    end
  end

  // gain compensation, product registered before rounding
  assign xc = st[CORDIC_STAGES].x;
  assign yc = st[CORDIC_STAGES].y;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= (VW+21)'(xc) * (VW+21)'(COMP_GAIN);
      py <= (VW+21)'(yc) * (VW+21)'(COMP_GAIN);
    end
  end
  assign pxr = (px + (VW+21)'(1 << 19)) >>> 20;
  assign pyr = (py + (VW+21)'(1 << 19)) >>> 20;
  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= pxr[VW-1:0];
      y_out <= pyr[VW-1:0];
    end
  end

endmodule

### rtl/vector_arrow_endpoint.sv
// top level: vector field arrow end point pipeline
// throughput: one transaction per cycle; a stall freezes the whole pipeline
// the output register holds a finished result while ready is low
// reset clears valid bits and restores the register defaults
module vector_arrow_endpoint
  import vae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] anchor_x,
  input  logic signed [23:0] anchor_y,
  input  logic signed [23:0] x_value,
  input  logic signed [23:0] y_value,
  input  logic        x_present,
  input  logic        y_present,
  input  logic        feature_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] start_x,
  output logic signed [23:0] start_y,
  output logic signed [23:0] end_x,
  output logic signed [23:0] end_y
);

  localparam int CL = CORDIC_STAGES + 3;     // cordic latency
  localparam int LAT = 2 * CL + 3;           // pipeline stages before output

  logic [1:0] field_type;
  logic ang_dir;
  logic ang_rad;
  logic signed [15:0] length_gain;
  logic signed [16:0] map_rotation;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_type <= FT_CARTESIAN;
      ang_dir <= 1'b0;
      ang_rad <= 1'b0;
      length_gain <= 16'sd256;
      map_rotation <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD_TYPE: field_type <= cfg_data[1:0];
        REG_ORIENT: ang_dir <= cfg_data[0];
        REG_UNITS: ang_rad <= cfg_data[0];
        REG_GAIN: length_gain <= cfg_data[15:0];
        REG_ROTATION: map_rotation <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  // side data delay lines
  logic signed [23:0] ax_d [LAT];
  logic signed [23:0] ay_d [LAT];
  logic feat_d [LAT];
  logic height;
  assign height = field_type[1];
  always_ff @(posedge clk) begin
    if (en) begin
      ax_d[0] <= anchor_x;
      ay_d[0] <= anchor_y;
      feat_d[0] <= feature_present;
      for (int i = 1; i < LAT; i++) begin
        ax_d[i] <= ax_d[i-1];
        ay_d[i] <= ay_d[i-1];
        feat_d[i] <= feat_d[i-1];
      end
    end
  end

  // stage 1: masking, gain products, angle fold
  logic signed [23:0] xv;
  logic signed [23:0] yv;
  logic signed [24:0] a_fold;
  logic signed [39:0] xg1;
  logic signed [39:0] yg1;
  logic signed [24:0] ang1;
  assign xv = x_present ? x_value : '0;
  assign yv = y_present ? y_value : '0;
  always_comb begin
    a_fold = 25'(yv);
    if (ang_dir) begin
      if (!ang_rad)
        a_fold = (25'(yv) <= DEG90) ? DEG90 - 25'(yv) : DEG450 - 25'(yv);
      else
        a_fold = (25'(yv) <= HALF_PI) ? HALF_PI - 25'(yv) : FIVE_HALF_PI - 25'(yv);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xg1 <= 40'(xv) * 40'(length_gain);
      yg1 <= 40'(yv) * 40'(length_gain);
      ang1 <= a_fold;
    end
  end

  // stage 2: degree phase split into a product and a small remainder term,
  // radian phase by scaling
  logic signed [39:0] xg2;
  logic signed [39:0] yg2;
  logic [31:0] ph2;
  logic [54:0] rad_p;
  logic signed [40:0] dkm;
  logic signed [29:0] dxs;
  logic [31:0] dk2;
  logic [28:0] dx2;
  logic [55:0] radm;
  assign dkm = 41'(ang1) * DEG_K;
  assign dxs = 30'(ang1) * DEG_R + DEG_OFS;
  assign radm = 56'($unsigned(56'(ang1))) * 56'(RAD_TO_PHASE);
  assign rad_p = radm[54:0];
  always_ff @(posedge clk) begin
    if (en) begin
      xg2 <= xg1;
      yg2 <= yg1;
      dk2 <= dkm[31:0];
      dx2 <= dxs[28:0];
      ph2 <= rad_p[47:16];
    end
  end

  // stage 3: remainder term divided by 45 through a reciprocal multiply
  logic signed [39:0] xg3;
  logic signed [39:0] yg3;
  logic [31:0] ph3;
  logic [58:0] dq;
  logic [31:0] deg_ph;
  assign dq = 59'(dx2) * 59'(DIV45_MAGIC);
  assign deg_ph = dk2 + 32'(dq[58:35]) - DEG_OFS_Q;
  always_ff @(posedge clk) begin
    if (en) begin
      xg3 <= xg2;
      yg3 <= yg2;
      ph3 <= ang_rad ? ph2 : deg_ph;
    end
  end

  // polar rotation
  vec_t p_x;
  vec_t p_y;
  logic [31:0] neg_ph;
  assign neg_ph = 32'd0 - ph3;
  vae_cordic u_polar (
    .clk, .en,
    .x_in('0), .y_in(VW'(xg3)), .phase(neg_ph),
    .x_out(p_x), .y_out(p_y)
  );

  // cartesian offsets delayed to match the polar cordic
  logic signed [39:0] xg_d [CL];
  logic signed [39:0] yg_d [CL];
  always_ff @(posedge clk) begin
    if (en) begin
      xg_d[0] <= xg3;
      yg_d[0] <= yg3;
      for (int i = 1; i < CL; i++) begin
        xg_d[i] <= xg_d[i-1];
        yg_d[i] <= yg_d[i-1];
      end
    end
  end

  // offset selection by field type
  vec_t dx;
  vec_t dy;
  always_comb begin
    if (height) begin
      dx = '0;
      dy = -VW'(yg_d[CL-1]);
    end else if (field_type == FT_POLAR) begin
      dx = p_x;
      dy = -p_y;
    end else begin
      dx = VW'(xg_d[CL-1]);
      dy = -VW'(yg_d[CL-1]);
    end
  end

  // map rotation phase, registered through rk_r/rx_r and then rot_ph_r
  logic signed [34:0] rkm;
  logic signed [24:0] rxs;
  logic [31:0] rk_r;
  logic [22:0] rx_r;
  logic [52:0] rq;
  logic [31:0] rot_ph_r;
  assign rkm = 35'(map_rotation) * ROT_K;
  assign rxs = 25'(map_rotation) * ROT_R + ROT_OFS;
  always_ff @(posedge clk) begin
    rk_r <= rkm[31:0];
    rx_r <= rxs[22:0];
  end
  assign rq = 53'(rx_r) * 53'(DIV45_MAGIC);
  always_ff @(posedge clk) rot_ph_r <= rk_r + 32'(rq[52:35]) - ROT_OFS_Q;

  vec_t r_x;
  vec_t r_y;
  vae_cordic u_map (
    .clk, .en,
    .x_in(dx), .y_in(dy), .phase(rot_ph_r),
    .x_out(r_x), .y_out(r_y)
  );

  vec_t dx_d [CL];
  vec_t dy_d [CL];
  always_ff @(posedge clk) begin
    if (en) begin
      dx_d[0] <= dx;
      dy_d[0] <= dy;
      for (int i = 1; i < CL; i++) begin
        dx_d[i] <= dx_d[i-1];
        dy_d[i] <= dy_d[i-1];
      end
    end
  end

  // final add, round and saturate
  logic use_rot;
  vec_t fx;
  vec_t fy;
  logic signed [VW:0] sx;
  logic signed [VW:0] sy;
  assign use_rot = !height && (map_rotation != 0);
  assign fx = use_rot ? r_x : dx_d[CL-1];
  assign fy = use_rot ? r_y : dy_d[CL-1];
  assign sx = ((VW+1)'(ax_d[LAT-1]) <<< 8) + (VW+1)'(fx) + (VW+1)'(128);
  assign sy = ((VW+1)'(ay_d[LAT-1]) <<< 8) + (VW+1)'(fy) + (VW+1)'(128);
  logic signed [VW:0] qx;
  logic signed [VW:0] qy;
  assign qx = sx >>> 8;
  assign qy = sy >>> 8;
  logic signed [23:0] ex;
  logic signed [23:0] ey;
  always_comb begin
    ex = (qx > (VW+1)'(OUT_MAX)) ? OUT_MAX : (qx < (VW+1)'(OUT_MIN)) ? OUT_MIN : qx[23:0];
    ey = (qy > (VW+1)'(OUT_MAX)) ? OUT_MAX : (qy < (VW+1)'(OUT_MIN)) ? OUT_MIN : qy[23:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (feat_d[LAT-1]) begin
        start_x <= ax_d[LAT-1];
        start_y <= ay_d[LAT-1];
        end_x <= ex;
        end_y <= ey;
      end else begin
        start_x <= '0;
        start_y <= 24'sd12800;
        end_x <= 24'sd25600;
        end_y <= 24'sd12800;
      end
    end
  end

endmodule

### rtl/vae_checker.sv
// port checker for the vector arrow endpoint, bound to the top level
module vae_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [23:0] start_x,
  input logic signed [23:0] end_x
);

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(end_x) && $stable(start_x))
    else $error("result changed while stalled");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  // no result right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector_arrow_endpoint vae_checker u_vae_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .start_x, .end_x
);

### sim/tb_vector_arrow_endpoint.sv
// testbench: vector arrow end point pipeline against a bit-accurate predictor
module tb_vector_arrow_endpoint;
  import vae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2 * (CORDIC_STAGES + 3) + 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] FT_HEIGHT = 2'd2;
  localparam logic [1:0] FT_SPARE = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [23:0] ax, ay, xv, yv;
    logic xp, yp, fp;
  } arrow_t;

  typedef struct {
    logic signed [23:0] sx, sy, ex, ey;
  } line_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] anchor_x = '0, anchor_y = '0, x_value = '0, y_value = '0;
  logic x_present = 1'b0, y_present = 1'b0, feature_present = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] start_x, start_y, end_x, end_y;

  vector_arrow_endpoint u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .anchor_x(anchor_x), .anchor_y(anchor_y), .x_value(x_value), .y_value(y_value),
    .x_present(x_present), .y_present(y_present), .feature_present(feature_present),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y)
  );

  always #1 clk = ~clk;

  // shadow copy of the configuration registers
  logic [1:0] sh_field_type;
  logic sh_orient, sh_units;
  longint sh_gain, sh_rotation;

  line_t expected_lines[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  bit no_gaps = 0;

  longint atan_tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // rotate a vector by a binary phase: quadrant fold then cordic
  function automatic void rotate_vec(inout longint x, inout longint y,
                                     input logic [31:0] ph);
    longint t, z, xs, ys;
    case (ph[31:30])
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    z = longint'({2'b00, ph[29:0]});
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tbl[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tbl[i];
      end
    end
    x = (x * 636751 + 524288) >>> 20;
    y = (y * 636751 + 524288) >>> 20;
  endfunction

  function automatic logic [31:0] wrap_phase(input longint a, input longint turn);
    longint r;
    r = a % turn;
    if (r < 0) r = r + turn;
    return 32'((r << 32) / turn);
  endfunction

  function automatic logic [31:0] angle_phase(input longint a);
    longint unsigned p;
    if (!sh_units) begin
      if (sh_orient) a = (a <= 23040) ? 23040 - a : 115200 - a;
      return wrap_phase(a, 92160);
    end
    if (sh_orient) a = (a <= 102944) ? 102944 - a : 514719 - a;
    p = longint'(a) * 64'd683565276;
    return 32'(p >> 16);
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return 24'(v);
  endfunction

  // expected line for one arrow under the current configuration
  function automatic line_t arrow_line(input arrow_t a);
    line_t r;
    longint xv, yv, dx, dy;
    bit height;
    if (!a.fp) begin
      r.sx = 0; r.sy = 12800; r.ex = 25600; r.ey = 12800;
      return r;
    end
    xv = a.xp ? longint'(a.xv) : 0;
    yv = a.yp ? longint'(a.yv) : 0;
    height = sh_field_type[1];
    dx = 0;
    dy = 0;
    if (height) begin
      dy = -(yv * sh_gain);
    end else if (sh_field_type == FT_POLAR) begin
      dy = xv * sh_gain;
      rotate_vec(dx, dy, 32'd0 - angle_phase(yv));
      dy = -dy;
    end else begin
      dx = xv * sh_gain;
      dy = -(yv * sh_gain);
    end
    if (!height && sh_rotation != 0) rotate_vec(dx, dy, wrap_phase(sh_rotation, 46080));
    r.sx = a.ax;
    r.sy = a.ay;
    r.ex = clamp24((longint'(a.ax) * 256 + dx + 128) >>> 8);
    r.ey = clamp24((longint'(a.ay) * 256 + dy + 128) >>> 8);
    return r;
  endfunction

  function automatic void shadow_write(input logic [2:0] idx, input logic [16:0] d);
    case (idx)
      REG_FIELD_TYPE: sh_field_type = d[1:0];
      REG_ORIENT: sh_orient = d[0];
      REG_UNITS: sh_units = d[0];
      REG_GAIN: sh_gain = longint'($signed(d[15:0]));
      REG_ROTATION: sh_rotation = longint'($signed(d));
      default: ;
    endcase
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern, with a randomly chosen mode
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 8 < 5);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    line_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                 start_x, start_y, end_x, end_y);
        errors++;
      end else begin
        e = expected_lines.pop_front();
        if (start_x !== e.sx) begin
          $display("%0t: start_x expected %0d actual %0d", $time, e.sx, start_x);
          errors++;
        end
        if (start_y !== e.sy) begin
          $display("%0t: start_y expected %0d actual %0d", $time, e.sy, start_y);
          errors++;
        end
        if (end_x !== e.ex) begin
          $display("%0t: end_x expected %0d actual %0d", $time, e.ex, end_x);
          errors++;
        end
        if (end_y !== e.ey) begin
          $display("%0t: end_y expected %0d actual %0d", $time, e.ey, end_y);
          errors++;
        end
      end
    end
  end

  // send one arrow transaction; called and returns at a falling edge
  task automatic send_arrow(input arrow_t a);
    int gap;
    anchor_x = a.ax; anchor_y = a.ay; x_value = a.xv; y_value = a.yv;
    x_present = a.xp; y_present = a.yp; feature_present = a.fp;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_lines.push_back(arrow_line(a));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] d);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = d;
    shadow_write(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [1:0] ft, input logic ori, input logic un,
                            input logic [15:0] gain, input logic [16:0] rot);
    wait_drain();
    write_reg(REG_FIELD_TYPE, {15'd0, ft});
    write_reg(REG_ORIENT, {16'd0, ori});
    write_reg(REG_UNITS, {16'd0, un});
    write_reg(REG_GAIN, {$urandom_range(0, 1) == 1, gain});
    write_reg(REG_ROTATION, rot);
  endtask

  function automatic arrow_t mk(input longint ax, ay, xv, yv, input bit xp = 1,
                                input bit yp = 1, input bit fp = 1);
    arrow_t a;
    a.ax = 24'(ax); a.ay = 24'(ay); a.xv = 24'(xv); a.yv = 24'(yv);
    a.xp = xp; a.yp = yp; a.fp = fp;
    return a;
  endfunction

  function automatic logic signed [23:0] rand_field();
    case ($urandom_range(0, 4))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      2: return 24'($signed($urandom_range(0, 524287)) - 262144);
      3: return 24'($signed($urandom_range(0, 131071)) - 65536);
      default: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7fffff;
          1: return 24'sh800000;
          2: return 24'sd0;
          default: return -24'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic arrow_t rand_arrow();
    arrow_t a;
    a.ax = rand_field(); a.ay = rand_field();
    a.xv = rand_field(); a.yv = rand_field();
    a.xp = ($urandom_range(0, 7) != 0);
    a.yp = ($urandom_range(0, 7) != 0);
    a.fp = ($urandom_range(0, 11) != 0);
    return a;
  endfunction

  // reset-default configuration, preview line, absent attributes, extremes
  task automatic test_defaults();
    send_arrow(mk(0, 0, 0, 0, 1, 1, 0));
    send_arrow(mk(-8388608, 8388607, 5, 7, 0, 0, 1));
    send_arrow(mk(100, -200, 256, 512));
    send_arrow(mk(8388607, -8388608, 8388607, -8388608));
    send_arrow(mk(-8388608, 8388607, -8388608, 8388607));
  endtask

  // polar angle conversions around the east-counterclockwise fold points
  task automatic test_polar();
    set_config(FT_POLAR, 1'b1, 1'b0, 16'd256, 17'd0);
    send_arrow(mk(0, 0, 2560, 23040));
    send_arrow(mk(0, 0, 2560, 23041));
    send_arrow(mk(0, 0, 2560, -92160 * 3 + 17));
    set_config(FT_POLAR, 1'b1, 1'b1, 16'd300, 17'd0);
    send_arrow(mk(10, 20, 2560, 102944));
    send_arrow(mk(10, 20, 2560, 102945));
    send_arrow(mk(10, 20, 2560, -8388608));
    set_config(FT_POLAR, 1'b0, 1'b1, 16'h8000, 17'd0);
    send_arrow(mk(0, 0, 8388607, 8388607));
    send_arrow(mk(0, 0, 4096, 51472, 1, 0));
  endtask

  // height mode, unused field type and gain extremes with saturation
  task automatic test_height();
    set_config(FT_HEIGHT, 1'b0, 1'b0, 16'h7fff, 17'd1000);
    send_arrow(mk(0, 0, 999, 8388607));
    send_arrow(mk(0, 0, 999, -8388608));
    set_config(FT_SPARE, 1'b1, 1'b1, 16'h8000, 17'd0);
    send_arrow(mk(5, 5, 1, 256));
    send_arrow(mk(5, 5, 1, -8388608));
  endtask

  // map rotation at its extremes, plus a write to an unused index
  task automatic test_rotation();
    set_config(FT_CARTESIAN, 1'b0, 1'b0, 16'd256, 17'h1_4c00);
    send_arrow(mk(0, 0, 2560, 1280));
    set_config(FT_CARTESIAN, 1'b0, 1'b0, 16'd256, 17'h0_b3ff);
    send_arrow(mk(0, 0, 2560, 1280));
    wait_drain();
    write_reg(REG_UNUSED, 17'h1ffff);
    send_arrow(mk(0, 0, -2560, 8388607));
    set_config(FT_POLAR, 1'b0, 1'b0, 16'h7fff, 17'h1_ffff);
    send_arrow(mk(0, 0, 8388607, 23040));
  endtask

  // random phases, each under a random configuration
  task automatic test_random();
    logic [15:0] gain;
    logic [16:0] rot;
    for (int ph = 0; ph < 10; ph++) begin
      gain = (ph == 0) ? 16'h8000 : (ph == 1) ? 16'h7fff : 16'($urandom);
      case ($urandom_range(0, 3))
        0: rot = 17'd0;
        1: rot = 17'($signed($urandom_range(0, 92159)) - 46080);
        default: rot = 17'($urandom);
      endcase
      if (ph == 2) rot = 17'h1_4c00;
      if (ph == 3) rot = 17'h0_b3ff;
      set_config(2'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 512)) : gain, rot);
      no_gaps = (ph % 4 == 1);
      for (int i = 0; i < 65; i++) send_arrow(rand_arrow());
    end
    no_gaps = 0;
  endtask

  initial begin
    sh_field_type = FT_CARTESIAN;
    sh_orient = 1'b0;
    sh_units = 1'b0;
    sh_gain = 256;
    sh_rotation = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_polar();
    test_height();
    test_rotation();
    test_random();
    in_valid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
